/* hdl/vtp_pkg.sv */
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the vertex taper profile unit.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam logic [1:0] CFG_AXIS  = 2'd0;
  localparam logic [1:0] CFG_MIN   = 2'd1;
  localparam logic [1:0] CFG_SIZE  = 2'd2;
  localparam logic [1:0] CFG_COUNT = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TAPER = 1'b1;

  localparam int SCALE_W  = 21;
  localparam int HEIGHT_W = 17;
  localparam int ENTRY_W  = SCALE_W + HEIGHT_W;

  // shared restoring divider: normalised height uses all 48 dividend bits,
  // interpolation offset uses 38
  localparam logic [5:0] DIV1_STEPS = 6'd48;
  localparam logic [5:0] DIV2_STEPS = 6'd38;

  localparam logic [17:0] H_ONE = 18'd65536;

  typedef struct packed {
    logic               action;
    logic [3:0]         point_slot;
    logic [20:0]        point_scale;
    logic [16:0]        point_height;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               no_segment;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic idx_init;
    logic idx_inc;
    logic rd_lo;
    logic rd_next;
    logic prev_load;
    logic interp_load;
    logic one_load;
    logic scale_fin;
    logic mul_a;
    logic mul_b;
    logic res_b;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic fail;
    logic h_one;
    logic n_zero;
    logic n_lt2;
    logic seg_hit;
    logic idx_last;
  } dp_sts_t;

endpackage

/* hdl/vtp_if.sv */
// ----------------------------------------------------------------------------
// vtp_in_if / vtp_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface vtp_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         point_slot;
  logic [20:0]        point_scale;
  logic [16:0]        point_height;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;

  modport source (output valid, action, point_slot, point_scale, point_height,
                  in_x, in_y, in_z, input ready);
  modport sink (input valid, action, point_slot, point_scale, point_height,
                in_x, in_y, in_z, output ready);
endinterface

interface vtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               no_segment;

  modport source (output valid, out_x, out_y, out_z, no_segment, input ready);
  modport sink (input valid, out_x, out_y, out_z, no_segment, output ready);
endinterface

/* hdl/vtp_ram.sv */
// ----------------------------------------------------------------------------
// vtp_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/vtp_datapath.sv */
// ----------------------------------------------------------------------------
// vtp_datapath
// Config registers, profile store, shared divider, search and scaling.
// ----------------------------------------------------------------------------
module vtp_datapath #(
  parameter int MAX_PROFILE_POINTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vtp_pkg::in_item_t   in_item,
  input  vtp_pkg::dp_cmd_t    cmd,
  output vtp_pkg::dp_sts_t    sts,
  output vtp_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  localparam int AW = $clog2(MAX_PROFILE_POINTS);
  localparam int IW = $clog2(MAX_PROFILE_POINTS + 1);

  // config
  logic [1:0]  axis_r, axis_nxt;
  logic [31:0] min_r, min_nxt;
  logic [30:0] size_r, size_nxt;
  logic [4:0]  count_r, count_nxt;

  // captured item
  logic               is_load_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic               diff_neg_r, size_zero_r;

  // divider
  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] dsr_r, dsr_nxt;
  logic [21:0] q_r, q_nxt;
  logic        ovf_r, ovf_nxt;

  // search / interpolation
  logic [IW-1:0] idx_r;
  logic [16:0]   ph_r;
  logic [20:0]   ps_r;
  logic [20:0]   sn_r;
  logic          neg_r;
  logic [20:0]   scale_r;
  logic          found_r;

  // scaling
  logic signed [53:0] prod_r;
  logic signed [31:0] res_a_r, res_b_r;
  vtp_pkg::out_item_t out_r;

  // combinational
  logic [1:0]               ax;
  logic signed [31:0]       sel_c;
  logic signed [32:0]       diff;
  logic [AW+3:0]            slot_ext;
  logic                     slot_ok;
  logic                     ram_we;
  logic [AW-1:0]            waddr, raddr;
  logic [vtp_pkg::ENTRY_W-1:0] rdata;
  logic [20:0]              rd_s;
  logic [16:0]              rd_h;
  logic [IW:0]              idx_p1;
  logic [IW-1:0]            n_lim;
  logic [17:0]              h;
  logic [31:0]              rem_sh;
  logic                     ge;
  logic [20:0]              ds;
  logic [16:0]              off, den;
  logic [37:0]              iprod;
  logic signed [31:0]       ca, cb;
  logic signed [53:0]       mprod;
  logic signed [31:0]       sat_v;
  logic signed [37:0]       sh;

  // ---------------- config ----------------
  always_comb begin
    axis_nxt  = axis_r;
    min_nxt   = min_r;
    size_nxt  = size_r;
    count_nxt = count_r;
    if (cfg_we) begin
      case (cfg_index)
        vtp_pkg::CFG_AXIS:  axis_nxt  = cfg_wdata[1:0];
        vtp_pkg::CFG_MIN:   min_nxt   = cfg_wdata;
        vtp_pkg::CFG_SIZE:  size_nxt  = cfg_wdata[30:0];
        vtp_pkg::CFG_COUNT: count_nxt = cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r  <= vtp_pkg::AXIS_Y;
      min_r   <= '0;
      size_r  <= 31'd65536;
      count_r <= 5'd2;
    end else begin
      axis_r  <= axis_nxt;
      min_r   <= min_nxt;
      size_r  <= size_nxt;
      count_r <= count_nxt;
    end
  end

  // axis code 3 behaves as z
  assign ax = (axis_r == 2'd3) ? vtp_pkg::AXIS_Z : axis_r;

  // ---------------- profile store ----------------
  assign slot_ext = {{AW{1'b0}}, in_item.point_slot};
  assign slot_ok  = {28'd0, in_item.point_slot} < 32'(MAX_PROFILE_POINTS);
  assign waddr    = slot_ext[AW-1:0];
  assign ram_we   = cmd.capture && (in_item.action == vtp_pkg::ACT_LOAD) && slot_ok;
  assign idx_p1   = {1'b0, idx_r} + 1'b1;

  always_comb begin
    if (cmd.rd_lo) begin
      raddr = '0;
    end else if (cmd.rd_next) begin
      raddr = idx_p1[AW-1:0];
    end else begin
      raddr = idx_r[AW-1:0];
    end
  end

  vtp_ram #(
    .WIDTH (vtp_pkg::ENTRY_W),
    .DEPTH (MAX_PROFILE_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_item.point_scale, in_item.point_height}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s = rdata[vtp_pkg::ENTRY_W-1:vtp_pkg::HEIGHT_W];
  assign rd_h = rdata[vtp_pkg::HEIGHT_W-1:0];

  assign n_lim = (32'(count_r) > 32'(MAX_PROFILE_POINTS)) ?
                 IW'(MAX_PROFILE_POINTS) : IW'(count_r);

  // ---------------- capture ----------------
  always_comb begin
    case (ax)
      vtp_pkg::AXIS_X: sel_c = in_item.in_x;
      vtp_pkg::AXIS_Y: sel_c = in_item.in_y;
      default:         sel_c = in_item.in_z;
    endcase
  end

  assign diff = $signed({sel_c[31], sel_c}) - $signed({min_r[31], min_r});

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_load_r   <= (in_item.action == vtp_pkg::ACT_LOAD);
      cx_r        <= in_item.in_x;
      cy_r        <= in_item.in_y;
      cz_r        <= in_item.in_z;
      diff_neg_r  <= diff[32];
      size_zero_r <= (size_r == '0);
    end
  end

  // ---------------- shared divider ----------------
  assign h      = q_r[17:0];
  assign rem_sh = {rem_r[30:0], dvd_r[47]};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  // interpolation set-up from previous and current profile entries
  assign ds    = (ps_r < rd_s) ? (rd_s - ps_r) : (ps_r - rd_s);
  assign off   = h[16:0] - rd_h;
  assign den   = ph_r - rd_h;
  assign iprod = {17'd0, ds} * {21'd0, off};

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    q_nxt   = q_r;
    ovf_nxt = ovf_r;
    if (cmd.capture) begin
      dvd_nxt = {diff[31:0], 16'd0};
      rem_nxt = '0;
      dsr_nxt = size_r;
      q_nxt   = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.interp_load) begin
      dvd_nxt = {iprod, 10'd0};
      rem_nxt = '0;
      dsr_nxt = {14'd0, den};
      q_nxt   = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.div_step) begin
      dvd_nxt = {dvd_r[46:0], 1'b0};
      rem_nxt = ge ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      q_nxt   = {q_r[20:0], ge};
      ovf_nxt = ovf_r | q_r[21];
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
  end

  // ---------------- search ----------------
  always_ff @(posedge clk) begin
    if (cmd.idx_init) begin
      idx_r <= IW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1[IW-1:0];
    end
    if (cmd.prev_load) begin
      ph_r <= rd_h;
      ps_r <= rd_s;
    end
    if (cmd.interp_load) begin
      sn_r  <= rd_s;
      neg_r <= ps_r < rd_s;
    end
    if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (cmd.one_load) begin
      scale_r <= rd_s;
      found_r <= 1'b1;
    end else if (cmd.scale_fin) begin
      scale_r <= neg_r ? (sn_r - q_r[20:0]) : (sn_r + q_r[20:0]);
      found_r <= 1'b1;
    end
  end

  assign sts.is_load  = is_load_r;
  assign sts.fail     = size_zero_r || diff_neg_r || ovf_r || (q_r[21:18] != 4'd0);
  assign sts.h_one    = (h == vtp_pkg::H_ONE);
  assign sts.n_zero   = (n_lim == '0);
  assign sts.n_lt2    = (n_lim < IW'(2));
  assign sts.seg_hit  = (h < {1'b0, ph_r}) && (h >= {1'b0, rd_h});
  assign sts.idx_last = idx_p1 >= {1'b0, n_lim};

  // ---------------- scaling ----------------
  // the two coordinates off the taper axis, in x, y, z order
  assign ca = (ax == vtp_pkg::AXIS_X) ? cy_r : cx_r;
  assign cb = (ax == vtp_pkg::AXIS_Z) ? cy_r : cz_r;

  assign mprod = (cmd.mul_a ? ca : cb) * $signed({1'b0, scale_r});
  assign sh    = 38'(prod_r >>> 16);

  always_comb begin
    if (sh > 38'sd2147483647) begin
      sat_v = 32'sh7FFFFFFF;
    end else if (sh < -38'sd2147483648) begin
      sat_v = 32'sh80000000;
    end else begin
      sat_v = sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_a || cmd.mul_b) begin
      prod_r <= mprod;
    end
    if (cmd.mul_b) begin
      res_a_r <= sat_v;
    end
    if (cmd.res_b) begin
      res_b_r <= sat_v;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_load_r) begin
        out_r <= '0;
      end else if (!found_r) begin
        out_r.out_x      <= cx_r;
        out_r.out_y      <= cy_r;
        out_r.out_z      <= cz_r;
        out_r.no_segment <= 1'b1;
      end else begin
        out_r.out_x      <= (ax == vtp_pkg::AXIS_X) ? cx_r : res_a_r;
        out_r.out_y      <= (ax == vtp_pkg::AXIS_Y) ? cy_r :
                            ((ax == vtp_pkg::AXIS_X) ? res_a_r : res_b_r);
        out_r.out_z      <= (ax == vtp_pkg::AXIS_Z) ? cz_r : res_b_r;
        out_r.no_segment <= 1'b0;
      end
    end
  end

  assign out_item = out_r;

endmodule

/* hdl/vtp_ctrl.sv */
// ----------------------------------------------------------------------------
// vtp_ctrl
// Sequencer: handshakes, divider step count and profile search order.
// ----------------------------------------------------------------------------
module vtp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vtp_pkg::dp_cmd_t  cmd,
  input  vtp_pkg::dp_sts_t  sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV1   = 4'd1;
  localparam logic [3:0] S_CHK    = 4'd2;
  localparam logic [3:0] S_ONE_RD = 4'd3;
  localparam logic [3:0] S_SRD0   = 4'd4;
  localparam logic [3:0] S_SCMP   = 4'd5;
  localparam logic [3:0] S_DIV2   = 4'd6;
  localparam logic [3:0] S_SFIN   = 4'd7;
  localparam logic [3:0] S_MULA   = 4'd8;
  localparam logic [3:0] S_MULB   = 4'd9;
  localparam logic [3:0] S_MULC   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = (in_action == vtp_pkg::ACT_LOAD) ? S_FIN : S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == vtp_pkg::DIV1_STEPS - 6'd1) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.fail) begin
          state_nxt = S_FIN;
        end else if (sts.h_one) begin
          if (sts.n_zero) begin
            state_nxt = S_FIN;
          end else begin
            cmd.rd_lo = 1'b1;
            state_nxt = S_ONE_RD;
          end
        end else if (sts.n_lt2) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_lo    = 1'b1;
          cmd.idx_init = 1'b1;
          state_nxt    = S_SRD0;
        end
      end
      S_ONE_RD: begin
        cmd.one_load = 1'b1;
        state_nxt    = S_MULA;
      end
      S_SRD0: begin
        cmd.prev_load = 1'b1;
        state_nxt     = S_SCMP;
      end
      S_SCMP: begin
        if (sts.seg_hit) begin
          cmd.interp_load = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = S_DIV2;
        end else if (sts.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.rd_next   = 1'b1;
          cmd.idx_inc   = 1'b1;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == vtp_pkg::DIV2_STEPS - 6'd1) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: begin
        cmd.scale_fin = 1'b1;
        state_nxt     = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd.res_b = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_hit_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP && sts.seg_hit) |=> (state_r == S_DIV2 && cnt_r == 6'd0))
    else $error("segment hit did not start interpolation divide");

  a_div1_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 && cnt_r != vtp_pkg::DIV1_STEPS - 6'd1) |=> state_r == S_DIV1)
    else $error("height divide left early");

  a_excl_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.div_step, cmd.interp_load, cmd.one_load, cmd.scale_fin}))
    else $error("conflicting divider and scale commands");
`endif

endmodule

/* hdl/vertex_taper_profile_unit.sv */
// Sequence: a load item goes straight to the result register; a vertex item runs the
//   height divide, then at most the search, interpolation divide and scaling.
// Throughput: one item at a time; the 48-step height divide and 38-step interpolation
//   divide share one bit-per-cycle restoring divider and set the item time.
// Reset (rst_n, synchronous, low): controller idle, no result held, config registers
//   back to axis y, min 0, size 1.0, two points; the profile store is not cleared.
// ----------------------------------------------------------------------------
// vertex_taper_profile_unit
// Tapers vertices along one axis by a piecewise linear scale profile.
// ----------------------------------------------------------------------------
module vertex_taper_profile_unit #(
  parameter int MAX_PROFILE_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  vtp_in_if.sink      in_ch,
  vtp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  vtp_pkg::in_item_t  in_item;
  vtp_pkg::out_item_t out_item;
  vtp_pkg::dp_cmd_t   cmd;
  vtp_pkg::dp_sts_t   sts;

  // input payload bundled for the datapath; it is only sampled on a transfer
  assign in_item.action       = in_ch.action;
  assign in_item.point_slot   = in_ch.point_slot;
  assign in_item.point_scale  = in_ch.point_scale;
  assign in_item.point_height = in_ch.point_height;
  assign in_item.in_x         = in_ch.in_x;
  assign in_item.in_y         = in_ch.in_y;
  assign in_item.in_z         = in_ch.in_z;

  // sequencer: owns both handshakes, so a held result never blocks the
  // next transfer in
  vtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: config, profile RAM, divider, multiplier, result register
  vtp_datapath #(
    .MAX_PROFILE_POINTS (MAX_PROFILE_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  assign out_ch.out_x      = out_item.out_x;
  assign out_ch.out_y      = out_item.out_y;
  assign out_ch.out_z      = out_item.out_z;
  assign out_ch.no_segment = out_item.no_segment;

endmodule

/* sim/vertex_taper_profile_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_taper_profile_unit_tb
// Self-checking bench: loads taper profiles, sends vertices through the unit
// under random idling on both channels and checks each result transfer
// against a local predictor of the taper arithmetic.
// ----------------------------------------------------------------------------
module vertex_taper_profile_unit_tb;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES  = 120;   // longer than the worst vertex latency
  localparam int PHASES         = 34;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  vtp_in_if  in_ch ();
  vtp_out_if out_ch ();

  vertex_taper_profile_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // pending stimulus and predicted results
  vtp_pkg::in_item_t  pending_items[$];
  vtp_pkg::out_item_t expected_vertices[$];

  // local copy of register and profile state
  logic [1:0] axis_sh;
  longint     min_sh;
  longint     size_sh;
  int         count_sh;
  longint     prof_scale[16];
  longint     prof_height[16];

  int errors;
  int results_seen;
  int in_gap;
  int out_stall;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // everything driven to a known value from time zero
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = vtp_pkg::CFG_AXIS;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.action          = vtp_pkg::ACT_LOAD;
    in_ch.point_slot      = '0;
    in_ch.point_scale     = '0;
    in_ch.point_height    = '0;
    in_ch.in_x            = '0;
    in_ch.in_y            = '0;
    in_ch.in_z            = '0;
    out_ch.ready          = 1'b0;
  end

  // floor(c * s / 2^16), saturated to signed 32 bits
  function automatic longint scaled_coord(longint c, longint s);
    longint r;
    if (c >= 0) r = (c * s) >>> 16;
    else        r = -((((-c) * s) + 65535) >>> 16);
    if (r > 64'sd2147483647)  r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // works out the result of one accepted item and updates the profile copy
  function automatic vtp_pkg::out_item_t taper_predict(vtp_pkg::in_item_t it);
    vtp_pkg::out_item_t res;
    longint    c[3];
    longint    v[3];
    longint    diff, hh, scale, hp, hn, sp, sn;
    int        ax, n;
    bit        found;
    res   = '0;
    found = 1'b0;
    scale = 0;
    if (it.action == vtp_pkg::ACT_LOAD) begin
      prof_scale[it.point_slot]  = it.point_scale;
      prof_height[it.point_slot] = it.point_height;
      return res;
    end
    c[0] = longint'(signed'(it.in_x));
    c[1] = longint'(signed'(it.in_y));
    c[2] = longint'(signed'(it.in_z));
    ax   = (axis_sh > vtp_pkg::AXIS_Z) ? 2 : int'(axis_sh);
    n    = (count_sh > 16) ? 16 : count_sh;
    if (size_sh != 0) begin
      diff = c[ax] - min_sh;
      if (diff >= 0) begin
        hh = (diff <<< 16) / size_sh;
        if (hh == 65536) begin
          found = (n >= 1);
          scale = prof_scale[0];
        end else begin
          for (int i = 1; i < n && !found; i++) begin
            hp = prof_height[i-1];
            hn = prof_height[i];
            if (hh < hp && hh >= hn) begin
              sp    = prof_scale[i-1];
              sn    = prof_scale[i];
              found = 1'b1;
              if (sp >= sn) scale = sn + ((sp - sn) * (hh - hn)) / (hp - hn);
              else          scale = sn - ((sn - sp) * (hh - hn)) / (hp - hn);
            end
          end
        end
      end
    end
    for (int k = 0; k < 3; k++)
      v[k] = (found && k != ax) ? scaled_coord(c[k], scale) : c[k];
    res.out_x      = v[0][31:0];
    res.out_y      = v[1][31:0];
    res.out_z      = v[2][31:0];
    res.no_segment = !found;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h0003_ffff);
      3:       return -$urandom_range(0, 32'h0003_ffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic vtp_pkg::in_item_t load_item(int slot, longint scl, longint hgt);
    vtp_pkg::in_item_t it;
    it              = '0;
    it.action       = vtp_pkg::ACT_LOAD;
    it.point_slot   = slot[3:0];
    it.point_scale  = scl[20:0];
    it.point_height = hgt[16:0];
    it.in_x         = $urandom;
    it.in_y         = $urandom;
    it.in_z         = $urandom;
    return it;
  endfunction

  // vertex whose axis coordinate mostly lands on a chosen height
  function automatic vtp_pkg::in_item_t vertex_item();
    vtp_pkg::in_item_t it;
    longint   t, coord;
    int       ax, r, n;
    it              = '0;
    it.action       = vtp_pkg::ACT_TAPER;
    it.point_slot   = $urandom;
    it.point_scale  = $urandom;
    it.point_height = $urandom;
    it.in_x         = any_coord();
    it.in_y         = any_coord();
    it.in_z         = any_coord();
    ax = (axis_sh > vtp_pkg::AXIS_Z) ? 2 : int'(axis_sh);
    n  = (count_sh > 16) ? 16 : ((count_sh < 1) ? 1 : count_sh);
    r  = $urandom_range(0, 19);
    if (r < 16) begin
      if (r < 2)      t = 65536;
      else if (r < 5) t = prof_height[$urandom_range(0, n - 1)];
      else if (r < 6) t = 65536 + $urandom_range(1, 100);
      else if (r < 7) t = -longint'($urandom_range(1, 100));
      else            t = $urandom_range(0, 65536);
      coord = min_sh + ((t * size_sh) >>> 16) + ((size_sh > 65536) ? 1 : 0);
      if (r == 6) coord = min_sh - $urandom_range(1, 50);
      if (coord >= -64'sd2147483648 && coord <= 64'sd2147483647) begin
        case (ax)
          0:       it.in_x = coord[31:0];
          1:       it.in_y = coord[31:0];
          default: it.in_z = coord[31:0];
        endcase
      end
    end
    return it;
  endfunction

  // appends one item to the stimulus queue
  task automatic queue_item(vtp_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endtask

  // descending profile, occasionally scrambled
  task automatic queue_profile(int n, bit scramble);
    longint hs[$];
    hs.delete();
    for (int i = 0; i < n - 2; i++) hs = {hs, longint'($urandom_range(1, 65535))};
    hs.rsort();
    hs = {longint'(($urandom_range(0, 7) == 0) ? $urandom_range(60000, 65536) : 65536), hs};
    hs = {hs, longint'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) : 0)};
    if (scramble) hs.shuffle();
    for (int i = 0; i < n; i++)
      queue_item(load_item(i, $urandom_range(0, 1048576), hs[i]));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      vtp_pkg::CFG_AXIS:  axis_sh  = val[1:0];
      vtp_pkg::CFG_MIN:   min_sh   = longint'(signed'(val));
      vtp_pkg::CFG_SIZE:  size_sh  = longint'(val[30:0]);
      default:            count_sh = int'(val[4:0]);
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all stimulus sent, all results back, unit settled
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_vertices.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one transfer per handshake, random gap before each item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit busy;
    vtp_pkg::in_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        it.action       = in_ch.action;
        it.point_slot   = in_ch.point_slot;
        it.point_scale  = in_ch.point_scale;
        it.point_height = in_ch.point_height;
        it.in_x         = in_ch.in_x;
        it.in_y         = in_ch.in_y;
        it.in_z         = in_ch.in_z;
        expected_vertices = {expected_vertices, taper_predict(it)};
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it                  = pending_items.pop_front();
          in_ch.action       <= it.action;
          in_ch.point_slot   <= it.point_slot;
          in_ch.point_scale  <= it.point_scale;
          in_ch.point_height <= it.point_height;
          in_ch.in_x         <= it.in_x;
          in_ch.in_y         <= it.in_y;
          in_ch.in_z         <= it.in_z;
          in_ch.valid        <= 1'b1;
          in_gap             <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compares each transfer with the oldest prediction.
  // Twice in the run it holds ready low for a long stretch so that the unit
  // fills up and stalls its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    vtp_pkg::out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
      results_seen <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_vertices.size() == 0) begin
          errors++;
          $display("%0t: unexpected result x=%h y=%h z=%h ns=%b", $realtime,
                   out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.no_segment);
        end else begin
          want = expected_vertices.pop_front();
          if (out_ch.out_x !== want.out_x || out_ch.out_y !== want.out_y ||
              out_ch.out_z !== want.out_z || out_ch.no_segment !== want.no_segment) begin
            errors++;
            $display("%0t: mismatch expected x=%h y=%h z=%h ns=%b actual x=%h y=%h z=%h ns=%b",
                     $realtime, want.out_x, want.out_y, want.out_z, want.no_segment,
                     out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.no_segment);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready &&
                   (results_seen == 299 || results_seen == 1299)) begin
        out_stall    <= 600;             // long hold-off
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall    <= pick_gap();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: counts cycles without a transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    int n, nv;
    vtp_pkg::in_item_t it;
    errors   = 0;
    axis_sh  = vtp_pkg::AXIS_Y;
    min_sh   = 0;
    size_sh  = 65536;
    count_sh = 2;
    for (int i = 0; i < 16; i++) begin
      prof_scale[i]  = 0;
      prof_height[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fill every slot (extreme scales and heights), then vertices under reset config
    queue_item(load_item(0, 1048576, 65536));
    queue_item(load_item(1, 0, 0));
    for (int i = 2; i < 16; i++)
      queue_item(load_item(i, 65536 * (i - 1), 65536 - 4096 * i));
    it = vertex_item(); it.in_y = 32'h0001_0000; it.in_x = 32'h7fff_ffff;
    it.in_z = 32'h8000_0000; queue_item(it);                   // height one
    it.in_y = 32'h0000_8000; queue_item(it);                    // middle, saturating
    it.in_y = 32'h0000_0000; queue_item(it);                    // height zero
    it.in_y = 32'hffff_ffff; queue_item(it);                    // below the range
    it.in_y = 32'h0001_0001; queue_item(it);                    // above the range
    it.in_y = 32'h0000_4000; it.in_x = 32'hffff_fff1; it.in_z = 32'h0000_000f;
    queue_item(it);                                             // negative x coordinate
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(vtp_pkg::CFG_AXIS, vtp_pkg::AXIS_X); write_reg(vtp_pkg::CFG_MIN, 32'h8000_0000);
          write_reg(vtp_pkg::CFG_SIZE, 32'h7fff_ffff); write_reg(vtp_pkg::CFG_COUNT, 32'd16);
        end
        1: begin
          write_reg(vtp_pkg::CFG_AXIS, 2'd3); write_reg(vtp_pkg::CFG_MIN, 32'h7fff_ffff);
          write_reg(vtp_pkg::CFG_SIZE, 32'd1); write_reg(vtp_pkg::CFG_COUNT, 32'd31);
        end
        2: begin
          write_reg(vtp_pkg::CFG_AXIS, vtp_pkg::AXIS_Z); write_reg(vtp_pkg::CFG_MIN, 32'hffff_0000);
          write_reg(vtp_pkg::CFG_SIZE, 32'd0); write_reg(vtp_pkg::CFG_COUNT, 32'd1);
        end
        3: begin
          write_reg(vtp_pkg::CFG_AXIS, vtp_pkg::AXIS_Y); write_reg(vtp_pkg::CFG_MIN, 32'd0);
          write_reg(vtp_pkg::CFG_SIZE, 32'd65536); write_reg(vtp_pkg::CFG_COUNT, 32'd0);
        end
        default: begin
          write_reg(vtp_pkg::CFG_AXIS, $urandom_range(0, 3));
          write_reg(vtp_pkg::CFG_MIN, ($urandom_range(0, 3) == 0) ? $urandom
                              : $urandom_range(0, 32'h0fff_ffff) - 32'h0800_0000);
          case ($urandom_range(0, 5))
            0:       write_reg(vtp_pkg::CFG_SIZE, $urandom_range(1, 64));
            1:       write_reg(vtp_pkg::CFG_SIZE, $urandom_range(1, 32'h7fff_ffff));
            default: write_reg(vtp_pkg::CFG_SIZE, $urandom_range(1, 32'h0100_0000));
          endcase
          write_reg(vtp_pkg::CFG_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                                     : $urandom_range(2, 16));
        end
      endcase
      n = (count_sh > 16) ? 16 : ((count_sh < 2) ? 2 : count_sh);
      queue_profile(n, $urandom_range(0, 9) == 0);
      nv = $urandom_range(40, 50);
      for (int k = 0; k < nv; k++) begin
        if ($urandom_range(0, 19) == 0)
          queue_item(load_item($urandom_range(0, 15), $urandom_range(0, 1048576),
                               $urandom_range(0, 65536)));
        else
          queue_item(vertex_item());
        // predictions use the profile copy only at acceptance
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
